FILE: hw/rtl/lrol_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrol_pkg;

    localparam int LEN_W      = 16;
    localparam int CLEN_W     = 12;
    localparam int COFF_W     = 20;
    localparam int OUT_SLOT_W = 4;
    // The running total never passes the requested offset, so one more bit than the
    // offset holds the total plus one entry length.
    localparam int SUM_W      = COFF_W + 1;

    localparam logic [LEN_W-1:0] PEND_MAX = 16'hFFFF;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FIND  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [CLEN_W-1:0] chunk_len;
        logic              ends_line;
        logic [COFF_W-1:0] find_offset;
    } lrol_item_t;

    typedef struct packed {
        logic                  found;
        logic [OUT_SLOT_W-1:0] slot;
        logic [LEN_W-1:0]      offset_in_entry;
        logic                  committed;
        logic                  ring_full;
        logic                  pending_saturated;
    } lrol_result_t;

    // Control from the sequencer to the accumulate and compare unit.
    typedef struct packed {
        logic start;
        logic len_valid;
    } lrol_walk_ctrl_t;

    // Status back from the accumulate and compare unit.
    typedef struct packed {
        logic             hit;
        logic [LEN_W-1:0] offs;
    } lrol_walk_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lrol_channels.sv
`timescale 1ns / 1ps
`default_nettype none

interface lrol_item_if import lrol_pkg::*; ();
    logic       valid;
    logic       ready;
    lrol_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lrol_result_if import lrol_pkg::*; ();
    logic         valid;
    logic         ready;
    lrol_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lrol_walk_acc.sv
`timescale 1ns / 1ps
`default_nettype none

// Accumulates entry lengths during a find and compares the running total
// against the requested offset, one entry per cycle.
module lrol_walk_acc import lrol_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lrol_walk_ctrl_t   ctrl,
    input  wire logic [LEN_W-1:0]  len,
    input  wire logic [COFF_W-1:0] coff,
    output lrol_walk_stat_t        stat
);

    logic [SUM_W-1:0] total_reg;
    logic [SUM_W-1:0] total_next;
    logic [SUM_W-1:0] total_plus;

    always_comb
    begin
        total_plus = total_reg + SUM_W'(len);
        stat.hit   = ctrl.len_valid && (total_plus > SUM_W'(coff));
        stat.offs  = LEN_W'(SUM_W'(coff) - total_reg);
        total_next = total_reg;
        if (ctrl.start)
        begin
            total_next = '0;
        end
        else if (ctrl.len_valid && !stat.hit)
        begin
            total_next = total_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/line_ring_offset_locator_core.sv
`timescale 1ns / 1ps
// A write beat's result is registered and shown in the cycle after it is accepted. A find
// beat walks the stored lines from the oldest, reads each length through the registered RAM
// port, adds it to a running total and registers its result on a hit or once all are read.
// One beat is handled at a time; a new beat waits until a find ends and the result drains.
// Reset clears the slot pointers, full flag, pending length and handshake state at
// once; the ring RAM is not cleared, since a find only reads slots already written.
`default_nettype none

module line_ring_offset_locator_core import lrol_pkg::*; #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lrol_item_if.sink     item,
    lrol_result_if.source result
);

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_FIND
    } state_t;

    // Ring of committed line lengths, one write and one registered read per cycle.
    logic [LEN_W-1:0] mem [RING_DEPTH];
    logic [LEN_W-1:0] rd_data_reg;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]   oldest_slot_reg, oldest_slot_next;
    logic                full_reg, full_next;
    logic [LEN_W-1:0]    pend_reg, pend_next;
    logic [COFF_W-1:0]   coff_reg, coff_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    issue_cnt_reg, issue_cnt_next;
    logic [SLOT_W-1:0]   rd_addr_reg, rd_addr_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [SLOT_W-1:0]   chk_slot_reg, chk_slot_next;
    logic                out_valid_reg, out_valid_next;
    lrol_result_t        out_data_reg, out_data_next;

    logic                accept;
    logic                mem_we;
    logic [LEN_W:0]      pend_sum;
    logic                pend_sat;
    logic [LEN_W-1:0]    pend_commit;
    logic [SLOT_W-1:0]   ws_inc;
    logic [SLOT_W-1:0]   os_inc;
    logic [CNT_W-1:0]    used_cnt;
    lrol_walk_ctrl_t     walk_ctrl;
    lrol_walk_stat_t     walk_stat;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    // A new beat is taken only between finds and when the result register is free
    // or is being emptied in this cycle.
    assign item.ready   = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign accept       = item.valid && item.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Pending length with saturation at its maximum.
    always_comb
    begin
        pend_sum    = {1'b0, pend_reg} + (LEN_W + 1)'(item.data.chunk_len);
        pend_sat    = (pend_sum >= {1'b0, PEND_MAX});
        pend_commit = pend_sat ? PEND_MAX : pend_sum[LEN_W-1:0];
        ws_inc      = next_slot(write_slot_reg);
        os_inc      = next_slot(oldest_slot_reg);
        if (write_slot_reg >= oldest_slot_reg)
        begin
            used_cnt = CNT_W'(write_slot_reg - oldest_slot_reg);
        end
        else
        begin
            used_cnt = CNT_W'(write_slot_reg) + CNT_W'(RING_DEPTH)
                       - CNT_W'(oldest_slot_reg);
        end
    end

    lrol_walk_acc u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (walk_ctrl),
        .len   (rd_data_reg),
        .coff  (coff_reg),
        .stat  (walk_stat)
    );

    always_comb
    begin
        state_next       = state_reg;
        write_slot_next  = write_slot_reg;
        oldest_slot_next = oldest_slot_reg;
        full_next        = full_reg;
        pend_next        = pend_reg;
        coff_next        = coff_reg;
        count_next       = count_reg;
        issue_cnt_next   = issue_cnt_reg;
        rd_addr_next     = rd_addr_reg;
        rd_valid_next    = 1'b0;
        chk_slot_next    = chk_slot_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_data_next    = out_data_reg;
        mem_we           = 1'b0;
        walk_ctrl.start     = 1'b0;
        walk_ctrl.len_valid = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.data.cmd == CMD_WRITE)
                    begin
                        pend_next = pend_commit;
                        out_data_next = '0;
                        out_data_next.pending_saturated = pend_sat;
                        if (item.data.ends_line)
                        begin
                            mem_we          = 1'b1;
                            pend_next       = '0;
                            write_slot_next = ws_inc;
                            if (full_reg)
                            begin
                                oldest_slot_next = os_inc;
                            end
                            if (ws_inc == (full_reg ? os_inc : oldest_slot_reg))
                            begin
                                full_next = 1'b1;
                            end
                            out_data_next.committed = 1'b1;
                        end
                        out_data_next.ring_full = full_next;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        // Start a walk from the oldest line.
                        walk_ctrl.start = 1'b1;
                        coff_next       = item.data.find_offset;
                        count_next      = full_reg ? CNT_W'(RING_DEPTH) : used_cnt;
                        issue_cnt_next  = '0;
                        rd_addr_next    = oldest_slot_reg;
                        chk_slot_next   = oldest_slot_reg;
                        state_next      = S_FIND;
                    end
                end
            end

            S_FIND:
            begin
                // Issue the next RAM read while the previous length is checked.
                if (issue_cnt_reg < count_reg)
                begin
                    rd_valid_next  = 1'b1;
                    rd_addr_next   = next_slot(rd_addr_reg);
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                walk_ctrl.len_valid = rd_valid_reg;
                if (rd_valid_reg && !walk_stat.hit)
                begin
                    chk_slot_next = next_slot(chk_slot_reg);
                end
                if (walk_stat.hit || (!rd_valid_reg && (issue_cnt_reg == count_reg)))
                begin
                    out_data_next = '0;
                    if (walk_stat.hit)
                    begin
                        out_data_next.found           = 1'b1;
                        out_data_next.slot            = OUT_SLOT_W'(chk_slot_reg);
                        out_data_next.offset_in_entry = walk_stat.offs;
                    end
                    out_data_next.ring_full = full_reg;
                    out_valid_next = 1'b1;
                    rd_valid_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            write_slot_reg  <= '0;
            oldest_slot_reg <= '0;
            full_reg        <= 1'b0;
            pend_reg        <= '0;
            count_reg       <= '0;
            issue_cnt_reg   <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            write_slot_reg  <= write_slot_next;
            oldest_slot_reg <= oldest_slot_next;
            full_reg        <= full_next;
            pend_reg        <= pend_next;
            count_reg       <= count_next;
            issue_cnt_reg   <= issue_cnt_next;
            rd_valid_reg    <= rd_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        coff_reg     <= coff_next;
        rd_addr_reg  <= rd_addr_next;
        chk_slot_reg <= chk_slot_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[write_slot_reg] <= pend_commit;
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

endmodule

`default_nettype wire
